>>> design/mma_pkg.sv
// Shared constants, types and state codes for the multichannel moving average block.
`default_nettype none

package mma_pkg;

  // Window and channel geometry
  localparam int WINDOW_DEPTH = 8;
  localparam int BUS_COUNT    = 2;
  localparam int SLOT_COUNT   = 8;
  localparam int FIELD_COUNT  = 3;
  localparam int CHANNELS     = BUS_COUNT * SLOT_COUNT * FIELD_COUNT;

  // Field widths on the ports
  localparam int SAMPLE_W = 24;
  localparam int BUS_W    = 1;
  localparam int SLOT_W   = 3;
  localparam int FIELD_W  = 2;
  localparam int CHNUM_W  = 6;
  localparam int FILL_W   = 4;

  // Internal widths
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HEAD_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int RCP_W   = SUM_W + 1;
  localparam int WIN_DEPTH = CHANNELS * WINDOW_DEPTH;
  localparam int WIN_AW  = $clog2(WIN_DEPTH);

  // Stream widths
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = BUS_W + SLOT_W + FIELD_W;
  localparam int OUT_TDATA_W = ((SAMPLE_W + FILL_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = CHNUM_W;

  // Per-channel bookkeeping record, one entry per channel in the channel RAM
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
    logic [HEAD_W-1:0]       head;
  } mma_chan_t;

  localparam int CHAN_W = $bits(mma_chan_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDCH,
    ST_RDWIN,
    ST_MUL,
    ST_FIX
  } mma_fsm_t;

endpackage

`default_nettype wire

>>> design/mma_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module mma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/multichannel_moving_average.sv
// Top level: per-channel moving average over a ring of recent samples.
//
// Input stream: one word per sample. in_tdata carries the Q15.8 sample,
// in_tuser carries bus, slot and field, which pick one of 48 channels.
// Out-of-range indices saturate to the last valid value.
// Output stream: one word per accepted input. out_tdata carries the window
// mean (truncated toward zero) and the channel's fill count, out_tuser the
// flat channel number.
// After an accept the item passes ST_RDCH, ST_RDWIN, ST_MUL and ST_FIX;
// out_tvalid is registered as ST_FIX ends when the output register is
// free. The pace is set by the channel RAM read, the window RAM read and
// the two-step reciprocal divide; a single item is in flight at a time.
// The output register decouples the sides: the next input is taken while a
// result waits; if the receiver stalls, the finished item holds in the
// final stage and in_tready stays low until the output register frees up.
// Reset: channel records read as zero via per-channel valid bits cleared
// together, so no clearing pass is needed; the window RAM is not cleared;
// an unwritten entry may be read but its value is used only on a full ring.
`default_nettype none

module multichannel_moving_average (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mma_pkg::IN_TDATA_W-1:0]  in_tdata,   // [23:0] sample
  input  wire logic [mma_pkg::IN_TUSER_W-1:0]  in_tuser,   // [0] bus, [3:1] slot, [5:4] field
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [mma_pkg::OUT_TDATA_W-1:0] out_tdata,  // [23:0] average, [27:24] fill count
  output logic      [mma_pkg::OUT_TUSER_W-1:0] out_tuser   // [5:0] channel number
);

  import mma_pkg::*;

  mma_fsm_t fsm_r, fsm_nxt;

  logic [CH_W-1:0]            ch_r, ch_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  mma_chan_t                  chan_r, chan_nxt;
  logic [HEAD_W-1:0]          widx_r, widx_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [SUM_W-1:0]           mag_r, mag_nxt;
  logic                       neg_r, neg_nxt;
  logic [SUM_W-1:0]           q0_r, q0_nxt;
  logic [CHANNELS-1:0]        ch_valid_r, ch_valid_nxt;

  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [SAMPLE_W-1:0]        out_avg_r, out_avg_nxt;
  logic [FILL_W-1:0]          out_fill_r, out_fill_nxt;
  logic [CHNUM_W-1:0]         out_ch_r, out_ch_nxt;

  // Input decode with saturation of the indices
  logic [BUS_W-1:0]   in_bus, bus_c;
  logic [SLOT_W-1:0]  in_slot, slot_c;
  logic [FIELD_W-1:0] in_field, field_c;
  logic [CH_W-1:0]    ch_in;

  assign in_bus   = in_tuser[0 +: BUS_W];
  assign in_slot  = in_tuser[BUS_W +: SLOT_W];
  assign in_field = in_tuser[BUS_W + SLOT_W +: FIELD_W];

  assign bus_c   = (32'(in_bus) >= BUS_COUNT) ? BUS_W'(BUS_COUNT - 1) : in_bus;
  assign slot_c  = (32'(in_slot) >= SLOT_COUNT) ? SLOT_W'(SLOT_COUNT - 1) : in_slot;
  assign field_c = (32'(in_field) >= FIELD_COUNT) ? FIELD_W'(FIELD_COUNT - 1) : in_field;
  assign ch_in   = CH_W'((32'(bus_c) * SLOT_COUNT + 32'(slot_c)) * FIELD_COUNT
                         + 32'(field_c));

  // Reciprocal table: floor(2^SUM_W / n); quotient estimate is low by at most one
  logic [RCP_W-1:0] rcp_tab [WINDOW_DEPTH+1];

  for (genvar g = 0; g <= WINDOW_DEPTH; g++) begin : g_rcp
    localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << SUM_W) / ((g == 0) ? 1 : g));
    assign rcp_tab[g] = RCP;
  end

  // Memories
  logic                  chr_rd_en, chr_wr_en;
  logic [CH_W-1:0]       chr_wr_addr;
  logic [CHAN_W-1:0]     chr_rd_data;
  mma_chan_t             chr_wr_data;

  logic                  win_rd_en, win_wr_en;
  logic [WIN_AW-1:0]     win_rd_addr, win_wr_addr;
  logic [SAMPLE_W-1:0]   win_rd_data;

  mma_ram #(
    .WIDTH (CHAN_W),
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk     (clk),
    .wr_en   (chr_wr_en),
    .wr_addr (chr_wr_addr),
    .wr_data (chr_wr_data),
    .rd_en   (chr_rd_en),
    .rd_addr (ch_in),
    .rd_data (chr_rd_data)
  );

  mma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WIN_DEPTH)
  ) u_win_ram (
    .clk     (clk),
    .wr_en   (win_wr_en),
    .wr_addr (win_wr_addr),
    .wr_data (sample_r),
    .rd_en   (win_rd_en),
    .rd_addr (win_rd_addr),
    .rd_data (win_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r        <= ST_IDLE;
      ch_valid_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      fsm_r        <= fsm_nxt;
      ch_valid_r   <= ch_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    sample_r   <= sample_nxt;
    chan_r     <= chan_nxt;
    widx_r     <= widx_nxt;
    cnt_r      <= cnt_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    q0_r       <= q0_nxt;
    out_avg_r  <= out_avg_nxt;
    out_fill_r <= out_fill_nxt;
    out_ch_r   <= out_ch_nxt;
  end

  always_comb begin
    mma_chan_t                  cur;
    logic [CNT_W:0]             wrap_sum;
    logic [HEAD_W-1:0]          idx;
    logic                       full;
    logic signed [SUM_W-1:0]    old_val;
    logic signed [SUM_W-1:0]    new_sum;
    logic [SUM_W+RCP_W-1:0]     prod;
    logic [SUM_W-1:0]           rem;
    logic [SUM_W-1:0]           q;
    logic [SUM_W-1:0]           q_s;

    fsm_nxt        = fsm_r;
    ch_nxt         = ch_r;
    sample_nxt     = sample_r;
    chan_nxt       = chan_r;
    widx_nxt       = widx_r;
    cnt_nxt        = cnt_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    q0_nxt         = q0_r;
    ch_valid_nxt   = ch_valid_r;
    out_tvalid_nxt = out_tvalid_r;
    out_avg_nxt    = out_avg_r;
    out_fill_nxt   = out_fill_r;
    out_ch_nxt     = out_ch_r;

    in_tready   = 1'b0;
    chr_rd_en   = 1'b0;
    chr_wr_en   = 1'b0;
    chr_wr_addr = ch_r;
    chr_wr_data = chan_r;
    win_rd_en   = 1'b0;
    win_wr_en   = 1'b0;
    win_rd_addr = '0;
    win_wr_addr = WIN_AW'(32'(ch_r) * WINDOW_DEPTH + 32'(widx_r));

    cur      = ch_valid_r[ch_r] ? mma_chan_t'(chr_rd_data) : '0;
    wrap_sum = (CNT_W+1)'(cur.head) + (CNT_W+1)'(cur.count);
    if (32'(wrap_sum) >= WINDOW_DEPTH) begin
      wrap_sum = wrap_sum - (CNT_W+1)'(WINDOW_DEPTH);
    end
    full    = (chan_r.count == CNT_W'(WINDOW_DEPTH));
    idx     = '0;
    old_val = full ? SUM_W'(signed'(win_rd_data)) : '0;
    new_sum = chan_r.sum + SUM_W'(sample_r) - old_val;
    prod    = mag_r * rcp_tab[cnt_r];
    rem     = mag_r - SUM_W'(q0_r * cnt_r);
    q       = (rem >= SUM_W'(cnt_r)) ? q0_r + SUM_W'(1) : q0_r;
    q_s     = neg_r ? SUM_W'(-q) : q;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (fsm_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        chr_rd_en = in_tvalid;
        if (in_tvalid) begin
          ch_nxt     = ch_in;
          sample_nxt = signed'(in_tdata[SAMPLE_W-1:0]);
          fsm_nxt    = ST_RDCH;
        end
      end
      ST_RDCH: begin
        // Full ring: oldest entry at head is replaced; else append after the tail
        if (cur.count == CNT_W'(WINDOW_DEPTH)) begin
          idx = cur.head;
        end else begin
          idx = HEAD_W'(wrap_sum);
        end
        win_rd_en   = 1'b1;
        win_rd_addr = WIN_AW'(32'(ch_r) * WINDOW_DEPTH + 32'(idx));
        chan_nxt    = cur;
        widx_nxt    = idx;
        fsm_nxt     = ST_RDWIN;
      end
      ST_RDWIN: begin
        win_wr_en = 1'b1;
        chr_wr_en = 1'b1;
        chr_wr_data.sum = new_sum;
        if (full) begin
          chr_wr_data.count = chan_r.count;
          chr_wr_data.head  = (32'(chan_r.head) == WINDOW_DEPTH - 1)
                              ? '0 : chan_r.head + HEAD_W'(1);
        end else begin
          chr_wr_data.count = chan_r.count + CNT_W'(1);
          chr_wr_data.head  = chan_r.head;
        end
        ch_valid_nxt[ch_r] = 1'b1;
        cnt_nxt = chr_wr_data.count;
        neg_nxt = new_sum[SUM_W-1];
        mag_nxt = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
        fsm_nxt = ST_MUL;
      end
      ST_MUL: begin
        q0_nxt  = SUM_W'(prod >> SUM_W);
        fsm_nxt = ST_FIX;
      end
      ST_FIX: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_avg_nxt    = q_s[SAMPLE_W-1:0];
          out_fill_nxt   = FILL_W'(cnt_r);
          out_ch_nxt     = CHNUM_W'(ch_r);
          fsm_nxt        = ST_IDLE;
        end
      end
      default: begin
        fsm_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_fill_r, out_avg_r});
  assign out_tuser  = out_ch_r;

endmodule

`default_nettype wire

>>> design/mma_checker.sv
// Port-level checker for the moving average block, bound to the top level.
`default_nettype none

module mma_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [mma_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic [mma_pkg::IN_TUSER_W-1:0]  in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [mma_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [mma_pkg::OUT_TUSER_W-1:0] out_tuser
);

  import mma_pkg::*;

  logic [FILL_W-1:0] fill;
  logic              in_hs;

  assign fill  = out_tdata[SAMPLE_W +: FILL_W];
  assign in_hs = in_tvalid && in_tready && (in_tdata == in_tdata) && (in_tuser == in_tuser);

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tuser) < CHANNELS)
    else $error("channel number out of range");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> fill != '0 && 32'(fill) <= WINDOW_DEPTH)
    else $error("fill count out of range");

  // One item in flight: no back-to-back accepts
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_hs |=> !in_tready)
    else $error("input accepted while an item is in progress");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (.*);

`default_nettype wire
